// File: rtl/tcw_pkg.sv
// ============================================================================
// tcw_pkg
// Shared types and constants of the text console writer: screen geometry,
// character codes, action codes and the controller/datapath interface.
// ============================================================================
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    // Cells that move during a scroll: every row but the top one shifts up.
    localparam int MOVE_N  = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = ATTR_W + CHAR_W;

    localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN   = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK    = 8'h20;
    localparam logic [ATTR_W-1:0] COLOR_RESET = 8'h0F;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SWEEP
    } t_state;

    typedef struct packed {
        logic load;        // latch the accepted item
        logic exec_put;    // carry out a put at the cursor
        logic exec_read;   // issue the read of one cell
        logic sweep_clr;   // start a scroll or clear sweep
        logic sweep_run;   // one step of the sweep
        logic finish;      // register the result and raise the strobe
    } t_ctl_cmd;

    typedef struct packed {
        t_action action;
        logic    need_scroll;
        logic    sweep_done;
    } t_dp_status;

endpackage

// File: rtl/tcw_ctrl.sv
// ============================================================================
// tcw_ctrl
// Controller of the text console writer: sequences the accept, execute,
// read and sweep phases of one item.
// ============================================================================
module tcw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  tcw_pkg::t_dp_status i_status,
    output tcw_pkg::t_ctl_cmd  o_cmd,
    output logic               o_busy
);
    import tcw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (i_status.action)
                    ACT_PUT: begin
                        o_cmd.exec_put = 1'b1;
                        if (i_status.need_scroll) begin
                            o_cmd.sweep_clr = 1'b1;
                            n_state         = ST_SWEEP;
                        end else begin
                            o_cmd.finish = 1'b1;
                            n_state      = ST_IDLE;
                        end
                    end
                    ACT_CLEAR: begin
                        o_cmd.sweep_clr = 1'b1;
                        n_state         = ST_SWEEP;
                    end
                    ACT_READ: begin
                        o_cmd.exec_read = 1'b1;
                        n_state         = ST_READ;
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                endcase
            end
            ST_READ: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_SWEEP: begin
                o_cmd.sweep_run = 1'b1;
                if (i_status.sweep_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/tcw_datapath.sv
// ============================================================================
// tcw_datapath
// Datapath of the text console writer: screen store, cursor, color register,
// sweep counter for scroll and clear, and the result registers.
// ============================================================================
module tcw_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcw_pkg::t_ctl_cmd             i_cmd,
    output tcw_pkg::t_dp_status           o_status,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_cfg_data,
    input  logic [1:0]                    i_action,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]     i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]     i_read_col,
    output logic [tcw_pkg::CELL_W-1:0]    o_cell_data,
    output logic [tcw_pkg::ROW_W-1:0]     o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]     o_cursor_col,
    output logic                          o_scrolled,
    output logic                          o_done
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    logic [ATTR_W-1:0] r_color;
    t_action           r_action;
    logic [CHAR_W-1:0] r_char;
    logic [ROW_W-1:0]  r_read_row;
    logic [COL_W-1:0]  r_read_col;
    logic [ROW_W-1:0]  r_cur_row;
    logic [COL_W-1:0]  r_cur_col;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_rd_ok;
    logic              r_scr_pend;
    logic [CELL_W-1:0] r_cell;
    logic              r_scrolled;
    logic              r_done;

    logic [ROW_W-1:0]  n_cur_row;
    logic [COL_W-1:0]  n_cur_col;
    logic              row_last;
    logic              col_last;
    logic              is_nl;
    logic              is_cr;
    logic              need_scroll;
    logic              read_in_range;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] req_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] blank_cell;

    assign row_last   = (int'(r_cur_row) == ROWS - 1);
    assign col_last   = (int'(r_cur_col) == COLUMNS - 1);
    assign is_nl      = (r_char == CH_NEWLINE);
    assign is_cr      = (r_char == CH_RETURN);
    assign need_scroll = row_last && (is_nl || (!is_cr && col_last));
    assign blank_cell = {r_color, CH_BLANK};

    assign cur_addr = ADDR_W'(int'(r_cur_row) * COLUMNS + int'(r_cur_col));
    assign req_addr = ADDR_W'(int'(r_read_row) * COLUMNS + int'(r_read_col));
    assign read_in_range = (int'(r_read_row) < ROWS) && (int'(r_read_col) < COLUMNS);

    // Cursor movement of a put; the row holds on the last row when it scrolls.
    always_comb begin
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        if (is_cr) begin
            n_cur_col = '0;
        end else if (is_nl || col_last) begin
            n_cur_col = '0;
            if (!row_last) begin
                n_cur_row = r_cur_row + 1'b1;
            end
        end else begin
            n_cur_col = r_cur_col + 1'b1;
        end
    end

    // At step c the sweep reads cell c+COLUMNS and writes cell c-1 with the word read at the step before.
    // A clear sweep writes blanks everywhere; a scroll blanks the bottom row.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_addr;
        wr_data = {r_color, r_char};
        rd_en   = 1'b0;
        rd_addr = req_addr;
        if (i_cmd.exec_put && !is_nl && !is_cr) begin
            wr_en = 1'b1;
        end
        if (i_cmd.exec_read && read_in_range) begin
            rd_en = 1'b1;
        end
        if (i_cmd.sweep_run) begin
            rd_addr = ADDR_W'(int'(r_cnt) + COLUMNS);
            rd_en   = (r_action != ACT_CLEAR) && (int'(r_cnt) < MOVE_N);
            wr_en   = (r_cnt != '0);
            wr_addr = ADDR_W'(r_cnt - 1'b1);
            if ((r_action != ACT_CLEAR) && (int'(r_cnt) <= MOVE_N)) begin
                wr_data = r_rdata;
            end else begin
                wr_data = blank_cell;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color    <= COLOR_RESET;
            r_cur_row  <= '0;
            r_cur_col  <= '0;
            r_done     <= 1'b0;
            r_scr_pend <= 1'b0;
            r_action   <= ACT_PUT;
            r_cnt      <= '0;
            r_rd_ok    <= 1'b0;
            r_cell     <= '0;
            r_scrolled <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cfg_we) begin
                r_color <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_action   <= t_action'(i_action);
                r_scr_pend <= 1'b0;
            end
            if (i_cmd.exec_put) begin
                r_cur_row  <= n_cur_row;
                r_cur_col  <= n_cur_col;
                r_scr_pend <= need_scroll;
            end
            if (i_cmd.exec_read) begin
                r_rd_ok <= read_in_range;
            end
            if (i_cmd.sweep_clr) begin
                r_cnt <= '0;
                if (r_action == ACT_CLEAR) begin
                    r_cur_row <= '0;
                    r_cur_col <= '0;
                end
            end else if (i_cmd.sweep_run) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.finish) begin
                r_cell     <= ((r_action == ACT_READ) && r_rd_ok) ? r_rdata : '0;
                r_scrolled <= (r_action == ACT_PUT) && r_scr_pend;
            end
        end
    end

    // Item fields need no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char     <= i_char_code;
            r_read_row <= i_read_row;
            r_read_col <= i_read_col;
        end
    end

    assign o_status.action      = r_action;
    assign o_status.need_scroll = need_scroll;
    assign o_status.sweep_done  = (r_cnt == CNT_W'(CELLS));

    assign o_cell_data  = r_cell;
    assign o_cursor_row = r_cur_row;
    assign o_cursor_col = r_cur_col;
    assign o_scrolled   = r_scrolled;
    assign o_done       = r_done;

endmodule

// File: rtl/text_console_writer_unit.sv
// ============================================================================
// text_console_writer_unit
// Character console engine with a screen store and cursor; put, clear and
// read actions, one result item per accepted item.
// ============================================================================
// An item is taken when start is high and busy is low; its result appears
// for one cycle with o_done high and cannot be held off. No new item is
// taken until the controller has finished the previous one. Clear and any
// put that scrolls walk the whole store through its single write port.
// The store is not cleared after reset; issue a clear before the first put
// or read.
module text_console_writer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_cfg_data,
    input  logic [1:0]                    i_action,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]     i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]     i_read_col,
    output logic [tcw_pkg::CELL_W-1:0]    o_cell_data,
    output logic [tcw_pkg::ROW_W-1:0]     o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]     o_cursor_col,
    output logic                          o_scrolled,
    output logic                          o_done
);
    import tcw_pkg::*;

    t_ctl_cmd   cmd;
    t_dp_status status;

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    tcw_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_action),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_cell_data  (o_cell_data),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_scrolled   (o_scrolled),
        .o_done       (o_done)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((int'(o_cursor_row) < ROWS) && (int'(o_cursor_col) < COLUMNS)))
        else $error("cursor outside the screen");

    a_idle_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> ($stable(o_cursor_row) && $stable(o_cursor_col)))
        else $error("cursor moved while no item was in progress");
`endif

endmodule

// File: sim/tcw_console_checker.sv
// ============================================================================
// tcw_console_checker
// Watches the item and result channels of the text console writer. It keeps
// its own screen store, cursor and text attribute, works out the report of
// every accepted item and compares each strobed result, field by field,
// with the oldest report still due.
// ============================================================================
module tcw_console_checker
    import tcw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic                i_cfg_we,
    input  logic [ATTR_W-1:0]   i_cfg_data,
    input  logic [1:0]          i_action,
    input  logic [CHAR_W-1:0]   i_char_code,
    input  logic [ROW_W-1:0]    i_read_row,
    input  logic [COL_W-1:0]    i_read_col,
    input  logic [CELL_W-1:0]   i_cell_data,
    input  logic [ROW_W-1:0]    i_cursor_row,
    input  logic [COL_W-1:0]    i_cursor_col,
    input  logic                i_scrolled,
    input  logic                i_done,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CELL_W-1:0] cell_val;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              scrolled;
    } console_report_t;

    console_report_t   due_reports[$];
    logic [CELL_W-1:0] screen [CELLS];
    logic [ATTR_W-1:0] text_attr = COLOR_RESET;
    int                cur_row = 0;
    int                cur_col = 0;
    int                fail_count = 0;
    int                report_no = 0;

    assign o_fail_count = fail_count;

    initial o_pending = 0;

    task automatic note_failure(input string what, input logic [CELL_W-1:0] want,
                                input logic [CELL_W-1:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("result %0d, %s: expected %h, got %h", report_no, what, want, got);
    endtask

    // Moves the cursor to the start of the next row; past the last row the store scrolls up
    // and the bottom row is blanked in the current attribute.
    function automatic logic line_feed();
        int i;
        cur_col = 0;
        cur_row++;
        if (cur_row < ROWS)
            return 1'b0;
        for (i = 0; i < MOVE_N; i++)
            screen[i] = screen[i + COLUMNS];
        for (i = MOVE_N; i < CELLS; i++)
            screen[i] = {text_attr, CH_BLANK};
        cur_row = ROWS - 1;
        return 1'b1;
    endfunction

    function automatic console_report_t advance_console(input logic [1:0] act,
                                                        input logic [CHAR_W-1:0] ch,
                                                        input logic [ROW_W-1:0] rr,
                                                        input logic [COL_W-1:0] rc);
        console_report_t rep;
        int i;
        rep = '0;
        case (act)
            ACT_PUT: begin
                if (ch == CH_NEWLINE) begin
                    rep.scrolled = line_feed();
                end else if (ch == CH_RETURN) begin
                    cur_col = 0;
                end else begin
                    screen[cur_row * COLUMNS + cur_col] = {text_attr, ch};
                    cur_col++;
                    if (cur_col >= COLUMNS)
                        rep.scrolled = line_feed();
                end
            end
            ACT_CLEAR: begin
                for (i = 0; i < CELLS; i++)
                    screen[i] = {text_attr, CH_BLANK};
                cur_row = 0;
                cur_col = 0;
            end
            ACT_READ: begin
                if (rr < ROWS && rc < COLUMNS)
                    rep.cell_val = screen[int'(rr) * COLUMNS + int'(rc)];
            end
            default: begin
            end
        endcase
        rep.row = ROW_W'(cur_row);
        rep.col = COL_W'(cur_col);
        return rep;
    endfunction

    always @(posedge i_clk) begin : watch
        console_report_t want;
        if (!i_rst_n) begin
            due_reports.delete();
            cur_row = 0;
            cur_col = 0;
            text_attr = COLOR_RESET;
        end else begin
            if (i_cfg_we)
                text_attr = i_cfg_data;
            // A result strobed at this edge belongs to an earlier item, so it
            // is retired before an item accepted at the same edge is added.
            if (i_done) begin
                report_no++;
                if (due_reports.size() == 0) begin
                    note_failure("result with no item pending", '0, i_cell_data);
                end else begin
                    want = due_reports.pop_front();
                    if (i_cell_data !== want.cell_val)
                        note_failure("cell_data", want.cell_val, i_cell_data);
                    if (i_cursor_row !== want.row)
                        note_failure("cursor_row", CELL_W'(want.row), CELL_W'(i_cursor_row));
                    if (i_cursor_col !== want.col)
                        note_failure("cursor_col", CELL_W'(want.col), CELL_W'(i_cursor_col));
                    if (i_scrolled !== want.scrolled)
                        note_failure("scrolled", CELL_W'(want.scrolled), CELL_W'(i_scrolled));
                end
            end
            if (i_start && !i_busy)
                due_reports.push_back(advance_console(i_action, i_char_code,
                                                      i_read_row, i_read_col));
        end
        o_pending <= due_reports.size();
    end

endmodule

// File: sim/text_console_writer_unit_tb.sv
// ============================================================================
// text_console_writer_unit_tb
// Drives the text console writer with a short directed run (clear, plain
// characters, newline, carriage return, the unused action, in- and
// out-of-range reads, attribute changes) and then random text lines, newline
// runs, reads, clears and noise under several text attributes, with random
// gaps between items. A checker beside the block predicts every result.
// ============================================================================
module text_console_writer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 6_000_000;
    localparam int          TAIL_CYCLES      = 2010;
    localparam int          RANDOM_PER_PHASE = 150;
    localparam int          PHASES           = 4;
    localparam logic [1:0]  ACT_UNUSED       = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_cfg_we = 1'b0;
    logic [ATTR_W-1:0]   i_cfg_data = '0;
    logic [1:0]          i_action = ACT_PUT;
    logic [CHAR_W-1:0]   i_char_code = '0;
    logic [ROW_W-1:0]    i_read_row = '0;
    logic [COL_W-1:0]    i_read_col = '0;
    logic [CELL_W-1:0]   o_cell_data;
    logic [ROW_W-1:0]    o_cursor_row;
    logic [COL_W-1:0]    o_cursor_col;
    logic                o_scrolled;
    logic                o_done;

    int                  fail_count;
    int                  pending;
    int                  items_sent = 0;
    int unsigned         cycle_count = 0;
    bit                  steady = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    text_console_writer_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_action),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_cell_data  (o_cell_data),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_scrolled   (o_scrolled),
        .o_done       (o_done)
    );

    tcw_console_checker u_console_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_action),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_cell_data  (o_cell_data),
        .i_cursor_row (o_cursor_row),
        .i_cursor_col (o_cursor_col),
        .i_scrolled   (o_scrolled),
        .i_done       (o_done),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("text_console_writer_unit: mismatch");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [CHAR_W-1:0] plain_char();
        logic [CHAR_W-1:0] ch;
        do
            ch = CHAR_W'($urandom_range(0, 255));
        while (ch == CH_NEWLINE || ch == CH_RETURN);
        return ch;
    endfunction

    // Presents one item, waits for the edge that accepts it and then for the random gap, if any. When no gap
    // follows, start stays high and the next call only changes the fields.
    task automatic send_item(input logic [1:0] act, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
        int gap;
        gap = pick_gap();
        start       <= 1'b1;
        i_action    <= act;
        i_char_code <= ch;
        i_read_row  <= rr;
        i_read_col  <= rc;
        do
            @(posedge i_clk);
        while (busy);
        if (act != ACT_UNUSED)
            items_sent++;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_put(input logic [CHAR_W-1:0] ch);
        send_item(ACT_PUT, ch, ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic send_read(input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
        send_item(ACT_READ, CHAR_W'($urandom), rr, rc);
    endtask

    task automatic send_clear();
        send_item(ACT_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
    endtask

    // Stops presenting items and waits until every result has come back.
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_color(input logic [ATTR_W-1:0] attr);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= attr;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input int count);
        int stop_at;
        int pick;
        int n;
        int k;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // A line of text, often long enough to wrap, usually ended.
                n = $urandom_range(0, 95);
                for (k = 0; k < n; k++)
                    send_put(plain_char());
                k = $urandom_range(0, 9);
                if (k < 7)
                    send_put(CH_NEWLINE);
                else if (k < 9)
                    send_put(CH_RETURN);
            end else if (pick < 63) begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(0, 6) == 0)
                        send_read(ROW_W'($urandom_range(0, 31)),
                                  COL_W'($urandom_range(0, 127)));
                    else if ($urandom_range(0, 1) == 0)
                        send_read(ROW_W'($urandom_range(18, ROWS - 1)),
                                  COL_W'($urandom_range(0, 47)));
                    else
                        send_read(ROW_W'($urandom_range(0, ROWS - 1)),
                                  COL_W'($urandom_range(0, COLUMNS - 1)));
                end
            end else if (pick < 78) begin
                n = $urandom_range(1, 30);
                for (k = 0; k < n; k++)
                    send_put(CH_NEWLINE);
            end else if (pick < 80) begin
                send_clear();
            end else begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    send_item(2'($urandom_range(0, 3)), CHAR_W'($urandom),
                              ROW_W'($urandom), COL_W'($urandom));
            end
        end
    endtask

    initial begin
        int p;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The store is undefined after reset, so a clear comes first.
        send_clear();
        send_read(5'd0, 7'd0);
        send_put(8'h48);
        send_put(8'h00);
        send_put(8'hFF);
        send_read(5'd0, 7'd0);
        send_read(5'd0, 7'd2);
        send_read(5'd0, 7'd3);
        send_put(CH_RETURN);
        send_put(8'h41);
        send_put(CH_NEWLINE);
        send_item(ACT_UNUSED, 8'hFF, 5'h1F, 7'h7F);
        send_read(ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
        send_read(5'h1F, 7'h7F);
        send_read(ROW_W'(ROWS), 7'd0);
        send_read(5'd0, COL_W'(COLUMNS));
        settle();

        set_color(8'h00);
        send_put(8'h5A);
        send_read(5'd1, 7'd0);
        send_clear();
        send_read(5'd1, 7'd0);
        send_read(5'd0, 7'd0);

        for (p = 0; p < PHASES; p++) begin
            settle();
            set_color(p == 0 ? 8'hFF : p == 2 ? 8'h00 : ATTR_W'($urandom));
            run_phase(RANDOM_PER_PHASE);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("text_console_writer_unit: match");
        else
            $display("text_console_writer_unit: mismatch");
        $finish;
    end

endmodule
